/* sv/pipt_pkg.sv */
`timescale 1ns / 1ps
package pipt_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	localparam int CMD_W = 2;
	localparam int LAT_W = 31;
	localparam int LON_W = 32;
	localparam int VTX_W = LAT_W + LON_W;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TEST   = 2'd2;

	typedef struct packed {
		logic clear;
		logic append;
		logic start;
		logic rd_en;
		logic load_res;
	} pipt_ctl_t;

	typedef struct packed {
		logic n_zero;
		logic read_last;
		logic pipe_busy;
	} pipt_stat_t;

endpackage

/* sv/pipt_ram.sv */
`timescale 1ns / 1ps
module pipt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(DEPTH)-1:0]    waddr,
	input  logic [WIDTH-1:0]            wdata,
	input  logic                        re,
	input  logic [$clog2(DEPTH)-1:0]    raddr,
	output logic [WIDTH-1:0]            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/pipt_ctrl.sv */
`timescale 1ns / 1ps
module pipt_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pipt_pkg::CMD_W-1:0]     cmd,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	input  pipt_pkg::pipt_stat_t           stat,
	output pipt_pkg::pipt_ctl_t            ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   accept;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		ctl.clear    = accept && (cmd == pipt_pkg::CMD_CLEAR);
		ctl.append   = accept && (cmd == pipt_pkg::CMD_APPEND);
		ctl.start    = accept && (cmd == pipt_pkg::CMD_TEST);
		ctl.rd_en    = (state_q == ST_WALK);
		ctl.load_res = (state_q == ST_DRAIN) && !stat.pipe_busy && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= stat.n_zero ? ST_DRAIN : ST_WALK;
					end
				end
				ST_WALK: begin
					if (stat.read_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (ctl.load_res) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/pipt_dp.sv */
`timescale 1ns / 1ps
module pipt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pipt_pkg::pipt_ctl_t                 ctl,
	input  logic signed [pipt_pkg::LAT_W-1:0]   in_lat,
	input  logic signed [pipt_pkg::LON_W-1:0]   in_lon,
	output pipt_pkg::pipt_stat_t                stat,
	output logic                                inside_res,
	output logic                                vertices_dropped
);

	localparam int DLAT_W = pipt_pkg::LAT_W + 1;
	localparam int DLON_W = pipt_pkg::LON_W + 1;
	localparam int PROD_W = DLAT_W + DLON_W;

	logic [pipt_pkg::CNT_W-1:0]        count_q;
	logic                              ovf_q;
	logic                              full;
	logic [pipt_pkg::IDX_W-1:0]        last_idx;

	logic signed [pipt_pkg::LAT_W-1:0] pt_lat_q;
	logic signed [pipt_pkg::LON_W-1:0] pt_lon_q;

	logic [pipt_pkg::IDX_W-1:0]        rd_ptr_q;
	logic                              first_q;
	logic                              rd_vld_q;
	logic                              rd_edge_q;
	logic [pipt_pkg::VTX_W-1:0]        rdata;
	logic [pipt_pkg::VTX_W-1:0]        prev_q;

	logic signed [pipt_pkg::LAT_W-1:0] lat_i, lat_j;
	logic signed [pipt_pkg::LON_W-1:0] lon_i, lon_j;

	logic                              valid_s1;
	logic                              straddle_s1;
	logic signed [DLAT_W-1:0]          dlat_p_s1, dlat_e_s1;
	logic signed [DLON_W-1:0]          dlon_e_s1, dlon_p_s1;

	logic                              valid_s2;
	logic                              straddle_s2;
	logic                              dpos_s2;
	logic signed [PROD_W-1:0]          lhs_s2, rhs_s2;
	logic                              crosses;

	logic                              inside_q;
	logic [1:0]                        res_q;

	assign full     = (count_q == pipt_pkg::CNT_W'(pipt_pkg::MAX_VERTICES));
	assign last_idx = pipt_pkg::IDX_W'(count_q - pipt_pkg::CNT_W'(1));

	assign stat.n_zero    = (count_q == '0);
	assign stat.read_last = !first_q && (rd_ptr_q == last_idx);
	assign stat.pipe_busy = rd_vld_q || valid_s1 || valid_s2;

	pipt_ram #(
		.WIDTH (pipt_pkg::VTX_W),
		.DEPTH (pipt_pkg::MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (ctl.append && !full),
		.waddr (count_q[pipt_pkg::IDX_W-1:0]),
		.wdata ({in_lon, in_lat}),
		.re    (ctl.rd_en),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			first_q   <= 1'b0;
			rd_vld_q  <= 1'b0;
			rd_edge_q <= 1'b0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (ctl.clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (ctl.append) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + pipt_pkg::CNT_W'(1);
				end
			end
			if (ctl.start) begin
				first_q <= 1'b1;
			end else if (ctl.rd_en) begin
				first_q <= 1'b0;
			end
			rd_vld_q  <= ctl.rd_en;
			rd_edge_q <= ctl.rd_en && !first_q;
			valid_s1  <= rd_edge_q;
			valid_s2  <= valid_s1;
		end
	end

	// The first read of a walk fetches the last vertex, so that the edge
	// closing the polygon is seen along with the first vertex.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			pt_lat_q <= in_lat;
			pt_lon_q <= in_lon;
			rd_ptr_q <= last_idx;
		end else if (ctl.rd_en) begin
			rd_ptr_q <= first_q ? '0 : rd_ptr_q + pipt_pkg::IDX_W'(1);
		end
		if (rd_vld_q) begin
			prev_q <= rdata;
		end
	end

	assign lat_i = rdata[pipt_pkg::LAT_W-1:0];
	assign lon_i = rdata[pipt_pkg::VTX_W-1:pipt_pkg::LAT_W];
	assign lat_j = prev_q[pipt_pkg::LAT_W-1:0];
	assign lon_j = prev_q[pipt_pkg::VTX_W-1:pipt_pkg::LAT_W];

	always_ff @(posedge clk) begin
		straddle_s1 <= (lon_i > pt_lon_q) != (lon_j > pt_lon_q);
		dlat_p_s1   <= DLAT_W'(pt_lat_q) - DLAT_W'(lat_i);
		dlat_e_s1   <= DLAT_W'(lat_j) - DLAT_W'(lat_i);
		dlon_e_s1   <= DLON_W'(lon_j) - DLON_W'(lon_i);
		dlon_p_s1   <= DLON_W'(pt_lon_q) - DLON_W'(lon_i);

		straddle_s2 <= straddle_s1;
		dpos_s2     <= !dlon_e_s1[DLON_W-1];
		lhs_s2      <= PROD_W'(dlat_p_s1) * PROD_W'(dlon_e_s1);
		rhs_s2      <= PROD_W'(dlat_e_s1) * PROD_W'(dlon_p_s1);
	end

	// A straddling edge never has equal endpoint longitudes, so the sign
	// bit alone tells which way the comparison runs.
	assign crosses = straddle_s2 && (dpos_s2 ? (lhs_s2 < rhs_s2) : (lhs_s2 > rhs_s2));

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			inside_q <= 1'b0;
		end else if (valid_s2 && crosses) begin
			inside_q <= !inside_q;
		end
		if (ctl.load_res) begin
			res_q <= {ovf_q, inside_q};
		end
	end

	assign inside_res       = res_q[0];
	assign vertices_dropped = res_q[1];

endmodule

/* sv/point_in_polygon_test_unit.sv */
`timescale 1ns / 1ps
// Channel  Dir  Words                     tdata (low bit up)                tuser
// s_*      in   commands and points       lat[30:0], lon[62:31], zero pad   cmd[1:0]
// m_*      out  one word per point test   inside_res[0], vertices_dropped[1], zero pad   -
//
// Clear and append act as their word is accepted. A point test with n stored vertices
// reads the last vertex and then every stored vertex in order (one read port, one vertex per
// cycle), then drains the difference, multiply and compare stages and loads the result
// register.
// With no vertices stored the reads and stages are skipped and the test goes
// straight to loading the result register.
// arst_n clears the vertex count and drop flag; memory contents are not reset.
// A finished result waits in the output register while new words are taken;
// a later test holds in its last step until that result has been taken.
module point_in_polygon_test_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // lat[30:0], lon[62:31], pad[63]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // inside_res[0], vertices_dropped[1], pad[7:2]
);

	pipt_pkg::pipt_ctl_t  ctl;
	pipt_pkg::pipt_stat_t stat;
	logic                 inside_res;
	logic                 vertices_dropped;

	pipt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	pipt_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.in_lat           (s_tdata[pipt_pkg::LAT_W-1:0]),
		.in_lon           (s_tdata[pipt_pkg::VTX_W-1:pipt_pkg::LAT_W]),
		.stat             (stat),
		.inside_res       (inside_res),
		.vertices_dropped (vertices_dropped)
	);

	assign m_tdata = {6'b0, vertices_dropped, inside_res};

endmodule

/* bench/point_in_polygon_test_unit_tb.sv */
`timescale 1ns / 1ps
module point_in_polygon_test_unit_tb;

	localparam logic [pipt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [pipt_pkg::LAT_W-1:0] LAT_MIN = {1'b1, {(pipt_pkg::LAT_W-1){1'b0}}};
	localparam logic signed [pipt_pkg::LAT_W-1:0] LAT_MAX = {1'b0, {(pipt_pkg::LAT_W-1){1'b1}}};
	localparam logic signed [pipt_pkg::LON_W-1:0] LON_MIN = {1'b1, {(pipt_pkg::LON_W-1){1'b0}}};
	localparam logic signed [pipt_pkg::LON_W-1:0] LON_MAX = {1'b0, {(pipt_pkg::LON_W-1){1'b1}}};

	localparam int WORD_TARGET = 850;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic dropped;
		logic in_poly;
	} pip_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // lat[30:0], lon[62:31], pad[63]
	logic [1:0]  s_tuser = '0;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // inside_res[0], vertices_dropped[1], pad[7:2]

	// Shadow copy of the polygon store, kept in step with accepted words.
	logic signed [pipt_pkg::LAT_W-1:0] poly_lat [pipt_pkg::MAX_VERTICES];
	logic signed [pipt_pkg::LON_W-1:0] poly_lon [pipt_pkg::MAX_VERTICES];
	int                                poly_count = 0;
	logic                              drop_flag = 1'b0;

	pip_result_t expected_results [$];

	int  words_sent = 0;
	int  mismatch_count = 0;
	int  error_count = 0;
	int  cycle_count = 0;
	bit  steady_flow = 1'b0;

	point_in_polygon_test_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int draw_gap();
		return steady_flow ? 0 : $urandom_range(0, 14);
	endfunction

	// Crossing-number parity over all edges, with the closing edge first.
	function automatic logic point_inside_poly(input logic signed [pipt_pkg::LAT_W-1:0] lat,
			input logic signed [pipt_pkg::LON_W-1:0] lon);
		longint plat, plon, lat_i, lon_i, lat_j, lon_j, span, lhs, rhs;
		logic   parity;
		logic   crossed;
		int     j;
		plat = lat;
		plon = lon;
		parity = 1'b0;
		j = (poly_count > 0) ? poly_count - 1 : 0;
		for (int i = 0; i < poly_count; i++) begin
			lat_i = poly_lat[i];
			lon_i = poly_lon[i];
			lat_j = poly_lat[j];
			lon_j = poly_lon[j];
			if ((lon_i > plon) != (lon_j > plon)) begin
				span = lon_j - lon_i;
				lhs = (plat - lat_i) * span;
				rhs = (lat_j - lat_i) * (plon - lon_i);
				crossed = (span > 0) ? (lhs < rhs) : (lhs > rhs);
				parity ^= crossed;
			end
			j = i;
		end
		return parity;
	endfunction

	function automatic void track_word(input logic [pipt_pkg::CMD_W-1:0] cmd,
			input logic signed [pipt_pkg::LAT_W-1:0] lat,
			input logic signed [pipt_pkg::LON_W-1:0] lon);
		pip_result_t res;
		case (cmd)
			pipt_pkg::CMD_CLEAR: begin
				poly_count = 0;
				drop_flag = 1'b0;
			end
			pipt_pkg::CMD_APPEND: begin
				if (poly_count >= pipt_pkg::MAX_VERTICES) begin
					drop_flag = 1'b1;
				end else begin
					poly_lat[poly_count] = lat;
					poly_lon[poly_count] = lon;
					poly_count++;
				end
			end
			pipt_pkg::CMD_TEST: begin
				res.in_poly = point_inside_poly(lat, lon);
				res.dropped = drop_flag;
				expected_results.push_back(res);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic longint near(input longint base, input int unsigned span_bits);
		return base + ($signed($urandom()) >>> (32 - span_bits));
	endfunction

	task automatic send_word(input logic [pipt_pkg::CMD_W-1:0] cmd,
			input logic signed [pipt_pkg::LAT_W-1:0] lat,
			input logic signed [pipt_pkg::LON_W-1:0] lon);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, lon, lat};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		track_word(cmd, lat, lon);
		if (cmd != CMD_UNUSED)
			words_sent++;
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		pip_result_t got;
		pip_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[1:0];
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result word: inside %b dropped %b",
						got.in_poly, got.dropped);
			end else begin
				want = expected_results.pop_front();
				if (got.in_poly !== want.in_poly || got.dropped !== want.dropped) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("result mismatch: expected inside %b dropped %b, got inside %b dropped %b",
							want.in_poly, want.dropped, got.in_poly, got.dropped);
				end
			end
		end
	end

	// Result side: a random stall (none in steady flow) before each word is taken.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Fills every entry, so later walks never see an unwritten one, then overflows.
	task automatic test_full_store();
		send_word(pipt_pkg::CMD_APPEND, LAT_MIN, LON_MIN);
		send_word(pipt_pkg::CMD_APPEND, LAT_MAX, LON_MIN);
		send_word(pipt_pkg::CMD_APPEND, LAT_MAX, LON_MAX);
		send_word(pipt_pkg::CMD_APPEND, LAT_MIN, LON_MAX);
		repeat (pipt_pkg::MAX_VERTICES - 4)
			send_word(pipt_pkg::CMD_APPEND, pipt_pkg::LAT_W'($urandom()), $urandom());
		send_word(pipt_pkg::CMD_APPEND, '0, '0);
		send_word(pipt_pkg::CMD_TEST, '0, '0);
		send_word(pipt_pkg::CMD_TEST, LAT_MAX, LON_MIN);
		wait_for_results();
	endtask

	task automatic test_small_polygons();
		steady_flow = 1'b1;
		send_word(pipt_pkg::CMD_CLEAR, LAT_MAX, LON_MAX);
		send_word(pipt_pkg::CMD_TEST, '0, '0);
		send_word(CMD_UNUSED, '1, '1);
		send_word(pipt_pkg::CMD_APPEND, 31'sd0, 32'sd0);
		send_word(pipt_pkg::CMD_TEST, -31'sd5, 32'sd0);
		send_word(pipt_pkg::CMD_APPEND, 31'sd1000, 32'sd1000);
		// With two vertices both edges cross together, so the parity cancels.
		send_word(pipt_pkg::CMD_TEST, 31'sd100, 32'sd500);
		send_word(pipt_pkg::CMD_APPEND, 31'sd0, 32'sd2000);
		send_word(pipt_pkg::CMD_TEST, 31'sd100, 32'sd1000);
		send_word(pipt_pkg::CMD_TEST, 31'sd2000, 32'sd1000);
		send_word(pipt_pkg::CMD_TEST, LAT_MIN, 32'sd1500);
		send_word(pipt_pkg::CMD_TEST, LAT_MAX, LON_MAX);
		wait_for_results();
		steady_flow = 1'b0;
	endtask

	task automatic test_random_polygons();
		int unsigned                       span_bits;
		int unsigned                       n_vert;
		int unsigned                       pick;
		int                                seq;
		logic signed [pipt_pkg::LAT_W-1:0] c_lat;
		logic signed [pipt_pkg::LAT_W-1:0] p_lat;
		logic signed [pipt_pkg::LON_W-1:0] c_lon;
		logic signed [pipt_pkg::LON_W-1:0] p_lon;
		seq = 0;
		while (words_sent < WORD_TARGET) begin
			steady_flow = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) < 8) begin
				c_lat = pipt_pkg::LAT_W'($urandom());
				c_lon = $urandom();
				span_bits = $urandom_range(3, 32);
				if ($urandom_range(0, 3) != 0)
					send_word(pipt_pkg::CMD_CLEAR, pipt_pkg::LAT_W'($urandom()), $urandom());
				n_vert = ($urandom_range(0, 7) == 0)
					? $urandom_range(9, pipt_pkg::MAX_VERTICES + 3) : $urandom_range(3, 8);
				repeat (n_vert)
					send_word(pipt_pkg::CMD_APPEND,
						pipt_pkg::LAT_W'(near(c_lat, span_bits)),
						pipt_pkg::LON_W'(near(c_lon, span_bits)));
				repeat ($urandom_range(1, 6)) begin
					p_lat = pipt_pkg::LAT_W'(near(c_lat, span_bits));
					p_lon = pipt_pkg::LON_W'(near(c_lon, span_bits));
					pick = $urandom_range(0, 7);
					// Points on a vertex longitude or latitude probe the strict compares.
					if (poly_count > 0 && pick == 0)
						p_lon = poly_lon[$urandom_range(0, poly_count - 1)];
					if (poly_count > 0 && pick == 1)
						p_lat = poly_lat[$urandom_range(0, poly_count - 1)];
					send_word(pipt_pkg::CMD_TEST, p_lat, p_lon);
				end
			end else begin
				repeat ($urandom_range(1, 6))
					send_word(pipt_pkg::CMD_W'($urandom_range(0, 3)),
						pipt_pkg::LAT_W'($urandom()), $urandom());
			end
			seq++;
			if (seq % 25 == 0)
				wait_for_results();
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_full_store();
		test_small_polygons();
		test_random_polygons();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			error_count += expected_results.size();
			$display("%0d expected result words never arrived", expected_results.size());
		end
		error_count += mismatch_count;
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/pipt_pkg.sv
sv/pipt_ram.sv
sv/pipt_ctrl.sv
sv/pipt_dp.sv
sv/point_in_polygon_test_unit.sv
bench/point_in_polygon_test_unit_tb.sv
